// ===== src/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

    // Build-time defaults
    localparam int MAX_SLOTS_DEF  = 32;
    localparam int KEY_SPACE_DEF  = 256;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths on the ports
    localparam int KEY_W      = 8;
    localparam int ACTIVE_W   = 6;
    localparam int SLOT_IDX_W = 5;
    localparam int USE_W      = 16;
    localparam int FILLED_W   = 6;
    localparam int STAMP_W    = 32;

    // Stream widths; the data widths are padded to whole bytes
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // Register value after reset
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd20;

endpackage

// ===== src/lfu_slot_replacement.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Content
// s_*       in         s_tvalid / s_tready      candidate key
// m_*       out        m_tvalid / m_tready      slot, evicted key, use count, fill; hit/evict flags
// cfg_*     in         cfg_valid / cfg_ready    active slot count
//
// A hit reads the key map and the slot word, then bumps the count; an insert into a
// free slot writes the map and the slot at once; an eviction first scans the filled slots:
// the victim search reads the slot memory one slot per cycle through its single read port.
// After reset the key map is cleared, one entry per cycle, over all min(KEY_SPACE, 256) entries,
// before the first word is taken. A word is taken while a result waits on m_*;
// a stalled result holds the sequencer in its last step.
module lfu_slot_replacement
    import lfu_pkg::*;
#(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int KEY_SPACE  = KEY_SPACE_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] candidate_key
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] slot_index, [12:5] evicted_key,
                                             // [28:13] use_count, [34:29] slots_filled
    output logic [OUT_USER_W-1:0] m_tuser,   // [0] was_hit, [1] did_evict
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ACTIVE_W-1:0]   cfg_data   // active_slots
);

    localparam int MAP_DEPTH = (KEY_SPACE < 256) ? KEY_SPACE : 256;
    localparam int KEY_BITS  = $clog2(MAP_DEPTH);
    localparam int SLOT_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FILL_BITS = $clog2(MAX_SLOTS + 1);
    localparam int MAP_W     = SLOT_BITS + 1;
    localparam int SW        = KEY_BITS + COUNT_BITS + STAMP_W;
    localparam int CMP_W     = 9;
    localparam logic [CMP_W-1:0] MAX9 = CMP_W'(MAX_SLOTS);
    localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_MREAD  = 4'd2;
    localparam logic [3:0] ST_MCHECK = 4'd3;
    localparam logic [3:0] ST_HUPD   = 4'd4;
    localparam logic [3:0] ST_SCAN   = 4'd5;
    localparam logic [3:0] ST_EVICT  = 4'd6;
    localparam logic [3:0] ST_EVINS  = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    // Control registers
    logic [3:0]          state_reg, state_next;
    logic [KEY_BITS-1:0] clr_reg, clr_next;
    logic [ACTIVE_W-1:0] active_reg, active_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [STAMP_W-1:0]  seq_reg, seq_next;
    logic [FILL_BITS-1:0] scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                out_vld_reg, out_vld_next;

    // Payload registers
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [SLOT_BITS-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [SLOT_BITS-1:0]  res_slot_reg, res_slot_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  res_evict_reg, res_evict_next;
    logic [KEY_BITS-1:0]   res_old_reg, res_old_next;
    logic [COUNT_BITS-1:0] res_cnt_reg, res_cnt_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic [STAMP_W-1:0]    best_stamp_reg, best_stamp_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    // Memory ports
    logic                  map_we;
    logic [KEY_BITS-1:0]   map_waddr;
    logic [MAP_W-1:0]      map_wdata;
    logic [MAP_W-1:0]      map_rdata;
    logic                  slot_we;
    logic [SLOT_BITS-1:0]  slot_waddr;
    logic [SW-1:0]         slot_wdata;
    logic [SLOT_BITS-1:0]  slot_raddr;
    logic [SW-1:0]         slot_rdata;

    // Key folding table and slot word fields
    logic [KEY_BITS-1:0]   fold_tab [256];
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [STAMP_W-1:0]    rd_stamp;
    logic [CMP_W-1:0]      act9, eff9;
    logic                  table_full;
    logic                  take;
    logic                  out_free;

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_fold
        assign fold_tab[gi] = KEY_BITS'(gi % KEY_SPACE);
    end

    assign rd_key   = slot_rdata[KEY_BITS-1:0];
    assign rd_cnt   = slot_rdata[KEY_BITS +: COUNT_BITS];
    assign rd_stamp = slot_rdata[KEY_BITS + COUNT_BITS +: STAMP_W];

    // Clamp the active size to 1..MAX_SLOTS
    assign act9 = CMP_W'(active_reg);
    always_comb
    begin
        if (act9 == '0)
        begin
            eff9 = CMP_W'(1);
        end
        else if (act9 > MAX9)
        begin
            eff9 = MAX9;
        end
        else
        begin
            eff9 = act9;
        end
    end
    assign table_full = CMP_W'(fill_reg) >= eff9;

    // Victim order: lower count, then older stamp, then lower slot
    assign take = (cmp_idx_reg == '0) || (rd_cnt < best_cnt_reg) ||
                  ((rd_cnt == best_cnt_reg) && (rd_stamp < best_stamp_reg));

    assign out_free  = !out_vld_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        active_next     = active_reg;
        fill_next       = fill_reg;
        seq_next        = seq_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        out_vld_next    = out_vld_reg;
        key_next        = key_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_slot_next   = res_slot_reg;
        res_hit_next    = res_hit_reg;
        res_evict_next  = res_evict_reg;
        res_old_next    = res_old_reg;
        res_cnt_next    = res_cnt_reg;
        best_cnt_next   = best_cnt_reg;
        best_stamp_next = best_stamp_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        map_we          = 1'b0;
        map_waddr       = key_reg;
        map_wdata       = '0;
        slot_we         = 1'b0;
        slot_waddr      = res_slot_reg;
        slot_wdata      = {seq_reg, CNT_ONE, key_reg};
        slot_raddr      = res_slot_reg;

        if (cfg_valid)
        begin
            active_next = cfg_data;
        end
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the key map to not held
                map_we    = 1'b1;
                map_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == KEY_BITS'(MAP_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next   = fold_tab[s_tdata[KEY_W-1:0]];
                    state_next = ST_MREAD;
                end
            end
            ST_MREAD:
            begin
                state_next = ST_MCHECK;
            end
            ST_MCHECK:
            begin
                res_old_next   = '0;
                res_evict_next = 1'b0;
                if (map_rdata[MAP_W-1])
                begin
                    // Hit: fetch the slot word
                    res_hit_next  = 1'b1;
                    res_slot_next = map_rdata[SLOT_BITS-1:0];
                    slot_raddr    = map_rdata[SLOT_BITS-1:0];
                    state_next    = ST_HUPD;
                end
                else if (!table_full)
                begin
                    // Insert into the next free slot
                    res_hit_next  = 1'b0;
                    res_slot_next = fill_reg[SLOT_BITS-1:0];
                    res_cnt_next  = CNT_ONE;
                    fill_next     = fill_reg + 1'b1;
                    map_we        = 1'b1;
                    map_wdata     = {1'b1, fill_reg[SLOT_BITS-1:0]};
                    slot_we       = 1'b1;
                    slot_waddr    = fill_reg[SLOT_BITS-1:0];
                    state_next    = ST_FINISH;
                end
                else
                begin
                    res_hit_next = 1'b0;
                    scan_next    = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_HUPD:
            begin
                // Bump the count, saturating
                res_cnt_next = (rd_cnt == CNT_TOP) ? rd_cnt : rd_cnt + 1'b1;
                slot_we      = 1'b1;
                slot_wdata   = {rd_stamp, res_cnt_next, rd_key};
                state_next   = ST_FINISH;
            end
            ST_SCAN:
            begin
                // Issue one slot read per cycle, compare the one before
                slot_raddr = scan_reg[SLOT_BITS-1:0];
                if (scan_reg < fill_reg)
                begin
                    scan_next    = scan_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[SLOT_BITS-1:0];
                end
                if (cmp_vld_reg)
                begin
                    if (take)
                    begin
                        res_slot_next   = cmp_idx_reg;
                        best_cnt_next   = rd_cnt;
                        best_stamp_next = rd_stamp;
                        res_old_next    = rd_key;
                    end
                    if (scan_reg == fill_reg)
                    begin
                        state_next = ST_EVICT;
                    end
                end
            end
            ST_EVICT:
            begin
                // Drop the victim's key from the map
                res_evict_next = 1'b1;
                res_cnt_next   = CNT_ONE;
                map_we         = 1'b1;
                map_waddr      = res_old_reg;
                map_wdata      = '0;
                state_next     = ST_EVINS;
            end
            ST_EVINS:
            begin
                map_we     = 1'b1;
                map_wdata  = {1'b1, res_slot_reg};
                slot_we    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = OUT_DATA_W'({FILLED_W'(fill_reg), USE_W'(res_cnt_reg),
                                                 KEY_W'(res_old_reg),
                                                 SLOT_IDX_W'(res_slot_reg)});
                    out_user_next = {res_evict_reg, res_hit_reg};
                    seq_next      = seq_reg + 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            active_reg  <= ACTIVE_RESET;
            fill_reg    <= '0;
            seq_reg     <= '0;
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            active_reg  <= active_next;
            fill_reg    <= fill_next;
            seq_reg     <= seq_next;
            scan_reg    <= scan_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_slot_reg   <= res_slot_next;
        res_hit_reg    <= res_hit_next;
        res_evict_reg  <= res_evict_next;
        res_old_reg    <= res_old_next;
        res_cnt_reg    <= res_cnt_next;
        best_cnt_reg   <= best_cnt_next;
        best_stamp_reg <= best_stamp_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    // Key to slot map: {held, slot}
    lfu_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_DEPTH),
        .ADDR_W(KEY_BITS)
    ) u_map (
        .clk  (clk),
        .we   (map_we),
        .waddr(map_waddr),
        .wdata(map_wdata),
        .raddr(key_reg),
        .rdata(map_rdata)
    );

    // Slot table: {stamp, count, key}
    lfu_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SLOTS),
        .ADDR_W(SLOT_BITS)
    ) u_slots (
        .clk  (clk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .raddr(slot_raddr),
        .rdata(slot_rdata)
    );

endmodule

// ===== src/lfu_ram.sv =====
`timescale 1ns / 1ps

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lfu_pkg::*;

    localparam int          TABLE_SLOTS = MAX_SLOTS_DEF;
    localparam int          KEY_COUNT   = KEY_SPACE_DEF;
    localparam int unsigned USE_TOP     = (1 << COUNT_BITS_DEF) - 1;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          TAIL_CYCLES = 48;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  was_hit;
        logic                  did_evict;
        logic [KEY_W-1:0]      evicted_key;
        logic [USE_W-1:0]      use_count;
        logic [FILLED_W-1:0]   slots_filled;
    } placement_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_TOGGLE,
        SINK_SPARSE,
        SINK_HOLD
    } sink_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [ACTIVE_W-1:0]   cfg_data  = '0;

    // Shadow of the replacement table
    bit                    key_held   [KEY_COUNT];
    int unsigned           key_slot   [KEY_COUNT];
    logic [KEY_W-1:0]      slot_owner [TABLE_SLOTS];
    int unsigned           slot_uses  [TABLE_SLOTS];
    int unsigned           slot_stamp [TABLE_SLOTS];
    int unsigned           fill_level = 0;
    int unsigned           item_seq   = 0;
    int unsigned           slot_limit = ACTIVE_RESET;

    logic [KEY_W-1:0]      pending_keys[$];
    placement_t            due_placements[$];

    bit                    steady     = 1'b0;
    int                    burst_left = 0;
    int                    gap_left   = 0;
    sink_mode_t            sink_mode  = SINK_OPEN;
    int                    sink_left  = 0;
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;

    lfu_slot_replacement i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one key to the shadow table and return the placement it causes
    function automatic placement_t place_key(input logic [KEY_W-1:0] key);
        placement_t  res;
        int unsigned limit;
        int unsigned slot;
        res   = '0;
        limit = slot_limit;
        if (limit < 1)
            limit = 1;
        if (limit > TABLE_SLOTS)
            limit = TABLE_SLOTS;
        if (key_held[key])
        begin
            slot        = key_slot[key];
            res.was_hit = 1'b1;
            if (slot_uses[slot] < USE_TOP)
                slot_uses[slot]++;
        end
        else
        begin
            if (fill_level < limit)
            begin
                slot = fill_level;
                fill_level++;
            end
            else
            begin
                // lowest count wins, then oldest stamp, then lowest slot
                slot = 0;
                for (int j = 1; j < fill_level && j < TABLE_SLOTS; j++)
                begin
                    if (slot_uses[j] < slot_uses[slot] ||
                        (slot_uses[j] == slot_uses[slot] && slot_stamp[j] < slot_stamp[slot]))
                        slot = j;
                end
                res.did_evict   = 1'b1;
                res.evicted_key = slot_owner[slot];
                key_held[slot_owner[slot]] = 1'b0;
            end
            key_held[key]    = 1'b1;
            key_slot[key]    = slot;
            slot_owner[slot] = key;
            slot_uses[slot]  = 1;
            slot_stamp[slot] = item_seq;
        end
        item_seq++;
        res.slot_index   = slot[SLOT_IDX_W-1:0];
        res.use_count    = slot_uses[slot][USE_W-1:0];
        res.slots_filled = fill_level[FILLED_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string line);
        $display("%0t ns: %s", $time, line);
        mismatch_count++;
    endtask

    // Sender: bursts of words with random gaps, predict on every accepted word
    always @(posedge clk)
    begin : sender
        bit fire;
        fire = s_tvalid && s_tready;
        if (rst_n)
        begin
            if (fire)
                due_placements.push_back(place_key(s_tdata[KEY_W-1:0]));
            if (s_tvalid && !fire)
            begin
                // hold the word until taken
            end
            else if (gap_left != 0 && !steady)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_keys.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_keys.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall pattern that switches to a random mode whenever its mode counter runs out
    always @(posedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else
        begin
            if (sink_left == 0)
            begin
                sink_mode <= sink_mode_t'($urandom_range(0, 3));
                sink_left <= $urandom_range(16, 64);
            end
            else
                sink_left <= sink_left - 1;
            case (sink_mode)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_TOGGLE: m_tready <= ~m_tready;
                SINK_SPARSE: m_tready <= ($urandom_range(0, 2) == 0);
                SINK_HOLD:   m_tready <= (sink_left < 4);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    // Monitor: compare each accepted word with the oldest placement due
    always @(posedge clk)
    begin : monitor
        placement_t got;
        placement_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.slot_index   = m_tdata[4:0];
            got.evicted_key  = m_tdata[12:5];
            got.use_count    = m_tdata[28:13];
            got.slots_filled = m_tdata[34:29];
            got.was_hit      = m_tuser[0];
            got.did_evict    = m_tuser[1];
            if (due_placements.size() == 0)
                flag_mismatch($sformatf("result word with nothing due: slot %0d", got.slot_index));
            else
            begin
                want = due_placements.pop_front();
                if (got.slot_index !== want.slot_index)
                    flag_mismatch($sformatf("slot_index %0d, want %0d",
                                            got.slot_index, want.slot_index));
                if (got.was_hit !== want.was_hit)
                    flag_mismatch($sformatf("was_hit %0b, want %0b", got.was_hit, want.was_hit));
                if (got.did_evict !== want.did_evict)
                    flag_mismatch($sformatf("did_evict %0b, want %0b",
                                            got.did_evict, want.did_evict));
                if (got.evicted_key !== want.evicted_key)
                    flag_mismatch($sformatf("evicted_key %0h, want %0h",
                                            got.evicted_key, want.evicted_key));
                if (got.use_count !== want.use_count)
                    flag_mismatch($sformatf("use_count %0d, want %0d",
                                            got.use_count, want.use_count));
                if (got.slots_filled !== want.slots_filled)
                    flag_mismatch($sformatf("slots_filled %0d, want %0d",
                                            got.slots_filled, want.slots_filled));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Wait until no word is queued, offered or due, then let the block settle
    task automatic wait_settled();
        do
            @(negedge clk);
        while (pending_keys.size() != 0 || s_tvalid || due_placements.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_active_slots(input logic [ACTIVE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        slot_limit  = value;
    endtask

    // Well-formed traffic: a working set with a hot core, plus stray keys
    task automatic queue_traffic(input int count);
        int width;
        int base;
        int pick;
        width = $urandom_range(2, 48);
        base  = $urandom_range(0, KEY_COUNT - 1);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                pending_keys.push_back(KEY_W'($urandom_range(0, KEY_COUNT - 1)));
            else if (pick < 50)
                pending_keys.push_back(KEY_W'(base + $urandom_range(0, 3)));
            else
                pending_keys.push_back(KEY_W'(base + $urandom_range(0, width - 1)));
        end
    endtask

    initial
    begin : stimulus
        logic [ACTIVE_W-1:0] settings[$];
        settings = '{6'd32, 6'd1, 6'd63, 6'd5, 6'($urandom_range(2, 31)), 6'd31,
                     6'd0, 6'($urandom_range(2, 31)), 6'd20};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size: fill a few slots with extreme keys, hit some of them
        pending_keys = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h55, 8'h01, 8'h80};
        wait_settled();

        // Zero acts as one slot: table is now over-full, evictions scan every filled slot
        set_active_slots(6'd0);
        pending_keys = '{8'h33, 8'h33, 8'h44, 8'h80, 8'h99, 8'h00};
        wait_settled();

        // Above the built size acts as the full table
        set_active_slots(6'd63);
        pending_keys = '{8'h10, 8'h11, 8'h12, 8'h10, 8'h7F, 8'hFE};
        wait_settled();

        // Random traffic across settings, pausing for a full drain between chunks
        foreach (settings[s])
        begin
            set_active_slots(settings[s]);
            repeat ($urandom_range(1, 3))
            begin
                queue_traffic($urandom_range(25, 50));
                wait_settled();
            end
        end

        // Drive one key back to back with the receiver always ready
        set_active_slots(6'd32);
        steady = 1'b1;
        repeat (40)
            pending_keys.push_back(8'hC3);
        wait_settled();
        steady = 1'b0;

        // Shrink under the fill so the hot entry competes in evictions
        set_active_slots(6'd3);
        queue_traffic(60);
        wait_settled();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== lfu_slot_replacement.f =====
src/lfu_pkg.sv
src/lfu_ram.sv
src/lfu_slot_replacement.sv
bench/tb_top.sv
